>>> rtl/blo_pkg.sv
// package for the block lru order list
// holds list sizing constants, command codes and the cell control struct
// no dependencies
package blo_pkg;

  // list capacity, its derived count width, and fixed widths
  localparam int LIST_DEPTH = 64;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ID_W       = 32;
  localparam int OCC_W      = 7;
  localparam int TOTAL_W    = 32;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic capture;      // item accepted, latch per-cell match
    logic push_wr;      // push commits, tail cell takes the id
    logic shift_found;  // remove commits, cells at or after the match shift
    logic shift_all;    // pop commits, every cell shifts
  } cell_ctl_t;

endpackage

>>> rtl/blo_cell.sv
// one cell of the ordered id row
// holds one entry and its match flag, passes the first-match flag onward
// depends on blo_pkg
module blo_cell (
  input  logic               clk,
  input  blo_pkg::cell_ctl_t ctl,
  input  logic [31:0]        id,
  input  logic               occupied,
  input  logic               tail,
  input  logic [31:0]        right_entry,
  input  logic               seen_in,
  output logic               seen_out,
  output logic [31:0]        entry
);
  import blo_pkg::*;

  logic match;
  logic shift;

  // first match at or before this cell
  assign seen_out = seen_in | match;
  assign shift    = ctl.shift_all | (ctl.shift_found & seen_out);

  // compare at accept time against the stored entry
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= occupied & (entry == id);
    end
  end

  // entry update: close the gap from the right, or take a pushed id
  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= right_entry;
    end else if (ctl.push_wr && tail) begin
      entry <= id;
    end
  end

endmodule

>>> rtl/block_lru_order_list.sv
// top level of the block lru order list: a row of blo_cell plus count and counter
// depends on blo_pkg and blo_cell
//
//   channel   handshake          payload
//   command   start / busy       command, block_id
//   result    done (one cycle)   head_id, found, empty_error, full_error,
//                                occupancy, block_total
//
// for each item, the accept edge latches the id and each cell compares it
// with its entry; the edge that ends busy runs the first-match ripple
// along the row and shifts or writes the cells in one step
// busy is high for the one cycle between those edges; done follows it and
// a new item may be accepted in the cycle where done is shown
// rst clears the count, the block counter and the handshake flags; entries
// are not cleared and only the first occupancy cells are ever read
// results cannot be stalled
module block_lru_order_list (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command,
  input  logic [blo_pkg::ID_W-1:0]    block_id,
  output logic                        done,
  output logic [blo_pkg::ID_W-1:0]    head_id,
  output logic                        found,
  output logic                        empty_error,
  output logic                        full_error,
  output logic [blo_pkg::OCC_W-1:0]   occupancy,
  output logic [blo_pkg::TOTAL_W-1:0] block_total
);
  import blo_pkg::*;

  localparam int LAST = LIST_DEPTH - 1;

  logic                accept;
  cmd_t                cmd_q;
  logic [ID_W-1:0]     id_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [TOTAL_W-1:0]  counter;
  logic [TOTAL_W-1:0]  counter_next;
  cell_ctl_t           ctl;
  logic [ID_W-1:0]     entry_q [LIST_DEPTH];
  logic                seen_chain [LIST_DEPTH+1];
  logic                hit;
  logic                is_full;
  logic                is_empty;
  logic [ID_W-1:0]     head_next;
  logic                found_next;
  logic                empty_next;
  logic                full_next;

  assign accept = start & ~busy;

  // latch the item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(command);
      id_q  <= block_id;
    end
  end

  // handshake flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= accept;
      done <= busy;
    end
  end

  // row of cells
  assign seen_chain[0] = 1'b0;
  assign hit           = seen_chain[LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] right_entry;
    if (i == LAST) begin : g_end
      assign right_entry = entry_q[i];
    end else begin : g_mid
      assign right_entry = entry_q[i+1];
    end

    blo_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .id          (accept ? block_id : id_q),
      .occupied    (CNT_W'(i) < count),
      .tail        (CNT_W'(i) == count),
      .right_entry (right_entry),
      .seen_in     (seen_chain[i]),
      .seen_out    (seen_chain[i+1]),
      .entry       (entry_q[i])
    );
  end

  // commit decode
  assign is_full  = (count == CNT_W'(LIST_DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    ctl          = '0;
    ctl.capture  = accept;
    count_next   = count;
    counter_next = counter;
    head_next    = '0;
    found_next   = 1'b0;
    empty_next   = 1'b0;
    full_next    = 1'b0;
    if (busy) begin
      case (cmd_q)
        CMD_PUSH: begin
          if (is_full) begin
            full_next = 1'b1;
          end else begin
            ctl.push_wr = 1'b1;
            count_next  = count + CNT_W'(1);
            if (counter != '1) begin
              counter_next = counter + TOTAL_W'(1);
            end
          end
        end
        CMD_REMOVE: begin
          if (hit) begin
            ctl.shift_found = 1'b1;
            found_next      = 1'b1;
            count_next      = count - CNT_W'(1);
            if (counter != '0) begin
              counter_next = counter - TOTAL_W'(1);
            end
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (is_empty) begin
            empty_next = 1'b1;
          end else begin
            head_next  = entry_q[0];
            found_next = 1'b1;
            if (cmd_q == CMD_POP) begin
              ctl.shift_all = 1'b1;
              count_next    = count - CNT_W'(1);
            end
          end
        end
        default: begin
          ctl.capture = accept;
        end
      endcase
    end
  end

  // count and block counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      counter <= '0;
    end else begin
      count   <= count_next;
      counter <= counter_next;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (busy) begin
      head_id     <= head_next;
      found       <= found_next;
      empty_error <= empty_next;
      full_error  <= full_next;
      occupancy   <= OCC_W'(count_next);
      block_total <= counter_next;
    end
  end

endmodule

>>> rtl/blo_checker.sv
// port-level checker for block_lru_order_list, with its bind
// depends on blo_pkg
module blo_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  command,
  input logic [blo_pkg::ID_W-1:0]    block_id,
  input logic                        done,
  input logic [blo_pkg::ID_W-1:0]    head_id,
  input logic                        found,
  input logic                        empty_error,
  input logic                        full_error,
  input logic [blo_pkg::OCC_W-1:0]   occupancy,
  input logic [blo_pkg::TOTAL_W-1:0] block_total
);
  import blo_pkg::*;

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // busy lasts one cycle and is followed by the result strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result strobe did not follow busy");

  // an error result never reports a hit, and the two errors never come together
  a_error_no_hit: assert property (@(posedge clk) disable iff (rst)
    done && (empty_error || full_error) |-> !found && !(empty_error && full_error))
    else $error("error result also reports a hit");

  // empty error leaves an empty list and a zero head
  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    done && empty_error |-> occupancy == '0 && head_id == '0)
    else $error("empty error with entries or a head");

  // full error only at capacity
  a_full_state: assert property (@(posedge clk) disable iff (rst)
    done && full_error |-> occupancy == OCC_W'(LIST_DEPTH))
    else $error("full error below capacity");

endmodule

bind block_lru_order_list blo_checker u_blo_checker (.*);

>>> tb/sv/blo_board_pkg.sv
// scoreboard for the block lru order list: outcome record and list tracker
// predicts each outcome from its own copy of the id list and block counter
// depends on blo_pkg
package blo_board_pkg;
  import blo_pkg::*;

  // one outcome as the block shows it on its result ports
  typedef struct packed {
    logic [ID_W-1:0]    head_id;
    logic               found;
    logic               empty_error;
    logic               full_error;
    logic [OCC_W-1:0]   occupancy;
    logic [TOTAL_W-1:0] block_total;
  } outcome_t;

  class evict_order_board;
    logic [ID_W-1:0]    resident_ids[$];
    logic [TOTAL_W-1:0] evict_total;
    outcome_t           pending_outcomes[$];
    int                 mismatches;

    function new();
      evict_total = '0;
      mismatches  = 0;
    endfunction

    // apply one accepted item to the tracked list and queue its outcome
    function void note_command(cmd_t cmd, logic [ID_W-1:0] id);
      outcome_t o;
      int       hit;
      o   = '0;
      hit = -1;
      case (cmd)
        CMD_PUSH: begin
          if (resident_ids.size() >= LIST_DEPTH) begin
            o.full_error = 1'b1;
          end else begin
            resident_ids.insert(resident_ids.size(), id);
            if (evict_total != '1) evict_total++;
          end
        end
        CMD_REMOVE: begin
          // first match wins, later duplicates stay
          foreach (resident_ids[i]) begin
            if (hit < 0 && resident_ids[i] == id) hit = i;
          end
          if (hit >= 0) begin
            resident_ids.delete(hit);
            o.found = 1'b1;
            if (evict_total != '0) evict_total--;
          end
        end
        default: begin
          // pop and peek share the empty check; only pop takes the head out
          if (resident_ids.size() == 0) begin
            o.empty_error = 1'b1;
          end else begin
            o.head_id = resident_ids[0];
            o.found   = 1'b1;
            if (cmd == CMD_POP) resident_ids.delete(0);
          end
        end
      endcase
      o.occupancy   = OCC_W'(resident_ids.size());
      o.block_total = evict_total;
      pending_outcomes.insert(pending_outcomes.size(), o);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    endfunction

    // compare one strobed outcome with the oldest pending one
    function void check_outcome(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_outcomes[0];
      pending_outcomes.delete(0);
      if (got.head_id !== want.head_id) report("head_id", want.head_id, got.head_id);
      if (got.found !== want.found) report("found", 32'(want.found), 32'(got.found));
      if (got.empty_error !== want.empty_error)
        report("empty_error", 32'(want.empty_error), 32'(got.empty_error));
      if (got.full_error !== want.full_error)
        report("full_error", 32'(want.full_error), 32'(got.full_error));
      if (got.occupancy !== want.occupancy)
        report("occupancy", 32'(want.occupancy), 32'(got.occupancy));
      if (got.block_total !== want.block_total)
        report("block_total", want.block_total, got.block_total);
    endfunction

    function int waiting();
      return pending_outcomes.size();
    endfunction

    // random id currently in the list, for removes that should hit
    function bit pick_resident(output logic [ID_W-1:0] id);
      id = '0;
      if (resident_ids.size() == 0) return 1'b0;
      id = resident_ids[$urandom_range(0, resident_ids.size() - 1)];
      return 1'b1;
    endfunction
  endclass

endpackage

>>> tb/sv/tb_block_lru_order_list.sv
// testbench top for the block lru order list: directed items, then phases of
// fill, drain and mixed traffic with random pacing, checked by the scoreboard
// depends on blo_pkg, blo_board_pkg and the block_lru_order_list rtl
module tb_block_lru_order_list;
  timeunit 1ns;
  timeprecision 1ps;
  import blo_pkg::*;
  import blo_board_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MODE_FILL    = 0;
  localparam int MODE_DRAIN   = 1;
  localparam int MODE_MIXED   = 2;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           command = CMD_PEEK;
  logic [ID_W-1:0]      block_id = '0;
  logic                 busy;
  logic                 done;
  logic [ID_W-1:0]      head_id;
  logic                 found;
  logic                 empty_error;
  logic                 full_error;
  logic [OCC_W-1:0]     occupancy;
  logic [TOTAL_W-1:0]   block_total;

  evict_order_board board;
  int               cycles = 0;

  block_lru_order_list dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .block_id(block_id),
    .done(done),
    .head_id(head_id),
    .found(found),
    .empty_error(empty_error),
    .full_error(full_error),
    .occupancy(occupancy),
    .block_total(block_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** block_lru_order_list: FAILED **");
      $finish;
    end
  end

  // results are strobed by done and cannot be held off
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      board.check_outcome({head_id, found, empty_error, full_error, occupancy, block_total});
  end

  // present one item and hold it until the block takes it
  task automatic issue(input cmd_t cmd, input logic [ID_W-1:0] id);
    start    <= 1'b1;
    command  <= cmd;
    block_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(cmd, id);
  endtask

  // random gap before an item: mostly none, some short, a few long
  task automatic pace(input bit idle_on);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return;
    n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // small pool for duplicates, extremes, and full-width values
  function automatic logic [ID_W-1:0] random_id();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return $urandom_range(0, 15);
      default:    return $urandom;
    endcase
  endfunction

  initial begin
    bit              idle_on;
    int              mode;
    int              span;
    int              issued;
    int              r;
    int              push_pct;
    int              remove_pct;
    int              pop_pct;
    cmd_t            cmd;
    logic [ID_W-1:0] id;

    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list errors, extremes, duplicates, head/middle/tail removal
    pace(1'b1); issue(CMD_PEEK, $urandom);
    pace(1'b1); issue(CMD_POP, $urandom);
    pace(1'b1); issue(CMD_REMOVE, 32'h0000_0005);
    pace(1'b1); issue(CMD_PUSH, 32'h0000_0000);
    pace(1'b1); issue(CMD_PUSH, 32'hFFFF_FFFF);
    pace(1'b1); issue(CMD_PUSH, 32'h5A5A_5A5A);
    pace(1'b1); issue(CMD_PUSH, 32'h0000_0000);
    pace(1'b1); issue(CMD_PUSH, 32'hA5A5_A5A5);
    pace(1'b1); issue(CMD_PEEK, $urandom);
    pace(1'b1); issue(CMD_REMOVE, 32'h0000_0000);
    pace(1'b1); issue(CMD_REMOVE, 32'h5A5A_5A5A);
    pace(1'b1); issue(CMD_REMOVE, 32'h1234_5678);
    pace(1'b1); issue(CMD_REMOVE, 32'hA5A5_A5A5);
    pace(1'b1); issue(CMD_POP, $urandom);
    pace(1'b1); issue(CMD_POP, $urandom);
    pace(1'b1); issue(CMD_POP, $urandom);
    pace(1'b1); issue(CMD_PEEK, $urandom);
    pace(1'b1); issue(CMD_PUSH, 32'h0000_0001);
    pace(1'b1); issue(CMD_REMOVE, 32'h0000_0001);

    // random phases; the first one is a fill phase, weighted toward pushes
    issued = 0;
    mode   = MODE_FILL;
    span   = 150;
    while (issued < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (mode)
        MODE_FILL:  begin push_pct = 75; remove_pct = 10; pop_pct = 8;  end
        MODE_DRAIN: begin push_pct = 15; remove_pct = 40; pop_pct = 35; end
        default:    begin push_pct = 35; remove_pct = 30; pop_pct = 20; end
      endcase
      repeat (span) begin
        if (issued >= RANDOM_ITEMS) break;
        r = $urandom_range(0, 99);
        if (r < push_pct) cmd = CMD_PUSH;
        else if (r < push_pct + remove_pct) cmd = CMD_REMOVE;
        else if (r < push_pct + remove_pct + pop_pct) cmd = CMD_POP;
        else cmd = CMD_PEEK;
        // most removes target an id that is in the list
        if (cmd == CMD_REMOVE && $urandom_range(0, 9) < 6) begin
          if (!board.pick_resident(id)) id = random_id();
        end else begin
          id = random_id();
        end
        pace(idle_on);
        issue(cmd, id);
        issued++;
      end
      mode = $urandom_range(MODE_FILL, MODE_MIXED);
      span = $urandom_range(20, 120);
    end

    // drain outstanding results
    start <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("** block_lru_order_list: PASSED **");
    end else begin
      $display("** block_lru_order_list: FAILED **");
    end
    $finish;
  end

endmodule
